// File: sv/assert_macros.svh
// Assertion macros shared by the level meter RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational invariant checked at every rising clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/pelm_pkg.sv
// Shared types, constants and the attenuation threshold table of the level meter.
// No dependencies; used by the controller, datapath and top level.
package pelm_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int PW_W       = $clog2(MAX_POINTS + 1);
   localparam int IDX_W      = 10;
   localparam int ATT_W      = 8;

   localparam logic [31:0] PEAK_FLOOR = 32'd17;
   localparam logic [63:0] STEP_RATIO = 64'd4054710589;

   // register indexes
   localparam logic [2:0] CSR_SAMPLE_FORMAT  = 3'd0;
   localparam logic [2:0] CSR_INPUT_GAIN     = 3'd1;
   localparam logic [2:0] CSR_ATTACK_COEF    = 3'd2;
   localparam logic [2:0] CSR_DECAY_COEF     = 3'd3;
   localparam logic [2:0] CSR_POINT_DURATION = 3'd4;

   // sample formats
   localparam logic [1:0] FMT_MONO_U8   = 2'd0;
   localparam logic [1:0] FMT_MONO_S16  = 2'd1;
   localparam logic [1:0] FMT_STEREO_U8 = 2'd2;
   localparam logic [1:0] FMT_STEREO_S16 = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_GAIN,
      OP_DECAY,
      OP_ATTACK,
      OP_MIX,
      OP_UPDATE,
      OP_SEARCH,
      OP_EMIT_PT,
      OP_EMIT_FL
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] bit_sel;   // search bit, MSB first
      logic       is_last;   // for OP_EMIT_PT
   } cmd_type;

   typedef struct packed {
      logic pt_pend;
      logic fl_pend;
      logic out_busy;
   } status_type;

   typedef logic [31:0] thr_arr_type [256];

   // t_{k+1} = floor(t_k * R / 2^32), done in two halves as the fixed-point spec does
   function automatic logic [63:0] step_down(input logic [63:0] t);
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] acc;
      hi  = t >> 16;
      lo  = t & 64'hFFFF;
      acc = hi * STEP_RATIO + ((lo * STEP_RATIO) >> 16);
      return acc >> 16;
   endfunction

   // Peak p (Q8.24) is below step k exactly when p < ceil(t_k / 2^24).
   // Entry 255 is never addressed by the search.
   function automatic thr_arr_type thr_table();
      thr_arr_type tab;
      logic [63:0] t;
      logic [63:0] c;
      t = 64'd1 << 48;
      for (int k = 0; k < 255; k++) begin
         c      = (t + 64'hFF_FFFF) >> 24;
         tab[k] = c[31:0];
         t      = step_down(t);
      end
      tab[255] = 32'd0;
      return tab;
   endfunction

   localparam thr_arr_type THR_TABLE = thr_table();

endpackage

// File: sv/pelm_req_if.sv
// Sample frame channel: valid/ready handshake with the frame payload.
// Depends on nothing.
interface pelm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_sample;
   logic signed [15:0] right_sample;
   logic               last_sample;

   modport source (output valid, left_sample, right_sample, last_sample, input ready);
   modport sink   (input valid, left_sample, right_sample, last_sample, output ready);
endinterface

// File: sv/pelm_rsp_if.sv
// Level point channel: valid/ready handshake with the point payload.
// Depends on nothing.
interface pelm_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] point_index;
   logic [7:0] attenuation;
   logic       is_last;

   modport source (output valid, point_index, attenuation, is_last, input ready);
   modport sink   (input valid, point_index, attenuation, is_last, output ready);
endinterface

// File: sv/pelm_ctrl.sv
// Sequencer of the level meter: steps the datapath through one frame.
// Depends on pelm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pelm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pelm_pkg::status_type st,
   output pelm_pkg::cmd_type    cmd
);
   import pelm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_GAIN,
      S_DECAY,
      S_ATTACK,
      S_MIX,
      S_UPDATE,
      S_SEARCH,
      S_EMIT_PT,
      S_EMIT_FL
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       emit_op;
   logic       in_flush;

   assign req_ready = (state_ff == S_IDLE);
   assign emit_op   = (cmd.op == OP_EMIT_PT) || (cmd.op == OP_EMIT_FL);
   assign in_flush  = (state_ff == S_EMIT_FL);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd.op      = OP_NONE;
      cmd.bit_sel = cnt_ff;
      cmd.is_last = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            cmd.op   = OP_GAIN;
            state_in = S_DECAY;
         end
         S_DECAY: begin
            cmd.op   = OP_DECAY;
            state_in = S_ATTACK;
         end
         S_ATTACK: begin
            cmd.op   = OP_ATTACK;
            state_in = S_MIX;
         end
         S_MIX: begin
            cmd.op   = OP_MIX;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.op   = OP_UPDATE;
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            // pend flags were settled by the update step
            if (!st.pt_pend && !st.fl_pend) begin
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_SEARCH;
               cnt_in = cnt_ff - 3'd1;
               if (cnt_ff == 3'd0) begin
                  state_in = st.pt_pend ? S_EMIT_PT : S_EMIT_FL;
               end
            end
         end
         S_EMIT_PT: begin
            if (!st.out_busy) begin
               cmd.op      = OP_EMIT_PT;
               cmd.is_last = !st.fl_pend;
               state_in    = st.fl_pend ? S_EMIT_FL : S_IDLE;
            end
         end
         S_EMIT_FL: begin
            if (!st.out_busy) begin
               cmd.op   = OP_EMIT_FL;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 3'd7;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= (state_ff == S_SEARCH) ? cnt_in : 3'd7;
      end
   end

   `ASSERT_IMPLIES(a_emit_free, clock, reset, emit_op, !st.out_busy, "emit into a busy output")
   `ASSERT_IMPLIES(a_flush_pending, clock, reset, in_flush, st.fl_pend, "stray flush state")

endmodule

// File: sv/pelm_dp.sv
// Datapath of the level meter: config registers, shared multiplier, envelope,
// point counters, threshold search and output stage. Depends on pelm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pelm_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_write_data,
   input  logic signed [15:0]   req_left_sample,
   input  logic signed [15:0]   req_right_sample,
   input  logic                 req_last_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [9:0]           rsp_point_index,
   output logic [7:0]           rsp_attenuation,
   output logic                 rsp_is_last,
   input  pelm_pkg::cmd_type    cmd,
   output pelm_pkg::status_type st
);
   import pelm_pkg::*;

   // configuration
   logic [1:0]  fmt_ff;
   logic [31:0] gain_ff;
   logic [15:0] attack_ff;
   logic [23:0] decay_ff;
   logic [15:0] duration_ff;

   // envelope and counters
   logic [31:0]     peak_ff;
   logic [15:0]     pos_ff;
   logic [PW_W-1:0] pw_ff;

   // per-frame working registers
   logic [16:0] mag_ff;
   logic        last_ff;
   logic [63:0] prod_ff;
   logic [31:0] x_ff;
   logic [31:0] p_ff;
   logic [31:0] diff_ff;
   logic        gt_ff;
   logic [31:0] srch_p_ff;
   logic [ATT_W-1:0] att_ff;
   logic        pt_pend_ff, fl_pend_ff;
   logic [IDX_W-1:0] pt_idx_ff, fl_idx_ff;

   // output stage
   logic             out_valid_ff;
   logic [IDX_W-1:0] out_idx_ff;
   logic [ATT_W-1:0] out_att_ff;
   logic             out_last_ff;

   logic upd_keep;

   // frame magnitude
   logic signed [9:0]  d_left, d_right, d_sum;
   logic signed [17:0] c_val, c_abs;
   logic [16:0]        mag_in;

   always_comb begin
      d_left  = $signed({2'b00, req_left_sample[7:0]}) - 10'sd128;
      d_right = $signed({2'b00, req_right_sample[7:0]}) - 10'sd128;
      d_sum   = d_left + d_right;
      unique case (fmt_ff)
         FMT_MONO_U8:   c_val = $signed({d_left[8:0], 9'b0});
         FMT_MONO_S16:  c_val = $signed({req_left_sample[15], req_left_sample, 1'b0});
         FMT_STEREO_U8: c_val = $signed({d_sum, 8'b0});
         default:       c_val = $signed({{2{req_left_sample[15]}}, req_left_sample})
                              + $signed({{2{req_right_sample[15]}}, req_right_sample});
      endcase
      c_abs  = c_val[17] ? -c_val : c_val;
      mag_in = c_abs[16:0];
   end

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [31:0] p_dec;
   logic [31:0] x_sat;

   always_comb begin
      unique case (cmd.op)
         OP_GAIN: begin
            mul_a = {15'b0, mag_ff};
            mul_b = gain_ff;
         end
         OP_DECAY: begin
            mul_a = peak_ff;
            mul_b = {8'b0, decay_ff};
         end
         default: begin
            mul_a = diff_ff;
            mul_b = {16'b0, attack_ff};
         end
      endcase
      mul_p = {32'b0, mul_a} * {32'b0, mul_b};
      x_sat = (prod_ff[63:40] != 24'd0) ? 32'hFFFF_FFFF : prod_ff[39:8];
      p_dec = prod_ff[55:24];
   end

   // envelope update and point bookkeeping
   logic [31:0]     p_sum, p_new;
   logic [16:0]     pos_nx;
   logic            reach, pw_full, pt_emit, fl_emit;
   logic [PW_W-1:0] pw_after;

   always_comb begin
      p_sum    = p_ff + (gt_ff ? prod_ff[47:16] : 32'd0);
      p_new    = (p_sum < PEAK_FLOOR) ? PEAK_FLOOR : p_sum;
      pos_nx   = {1'b0, pos_ff} + 17'd1;
      // a zero duration behaves like one
      reach    = pos_nx >= {1'b0, duration_ff};
      pw_full  = pw_ff >= PW_W'(MAX_POINTS);
      pt_emit  = reach && !pw_full;
      pw_after = pt_emit ? pw_ff + PW_W'(1) : pw_ff;
      fl_emit  = last_ff && (pw_after < PW_W'(MAX_POINTS));
   end

   // threshold search, one bit per step
   logic [ATT_W-1:0] cand, thr_idx;
   always_comb begin
      cand    = att_ff | (ATT_W'(1) << cmd.bit_sel);
      thr_idx = cand - ATT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff      <= FMT_MONO_S16;
         gain_ff     <= 32'd65536;
         attack_ff   <= 16'd2143;
         decay_ff    <= 24'd16775019;
         duration_ff <= 16'd960;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SAMPLE_FORMAT:  fmt_ff      <= csr_write_data[1:0];
            CSR_INPUT_GAIN:     gain_ff     <= csr_write_data;
            CSR_ATTACK_COEF:    attack_ff   <= csr_write_data[15:0];
            CSR_DECAY_COEF:     decay_ff    <= csr_write_data[23:0];
            CSR_POINT_DURATION: duration_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff    <= 32'd0;
         pos_ff     <= 16'd0;
         pw_ff      <= '0;
         pt_pend_ff <= 1'b0;
         fl_pend_ff <= 1'b0;
      end else if (cmd.op == OP_UPDATE) begin
         peak_ff    <= last_ff ? 32'd0 : p_new;
         pos_ff     <= (reach || last_ff) ? 16'd0 : pos_nx[15:0];
         pw_ff      <= last_ff ? '0 : pw_after;
         pt_pend_ff <= pt_emit;
         fl_pend_ff <= fl_emit;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            mag_ff  <= mag_in;
            last_ff <= req_last_sample;
         end
         OP_GAIN:  prod_ff <= mul_p;
         OP_DECAY: begin
            x_ff    <= x_sat;
            prod_ff <= mul_p;
         end
         OP_ATTACK: begin
            p_ff    <= p_dec;
            gt_ff   <= x_ff > p_dec;
            diff_ff <= x_ff - p_dec;
         end
         OP_MIX:    prod_ff <= mul_p;
         OP_UPDATE: begin
            srch_p_ff <= p_new;
            att_ff    <= '0;
            pt_idx_ff <= pw_ff[IDX_W-1:0];
            fl_idx_ff <= pw_after[IDX_W-1:0];
         end
         OP_SEARCH: begin
            if (srch_p_ff < THR_TABLE[thr_idx]) begin
               att_ff <= cand;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT_PT || cmd.op == OP_EMIT_FL) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT_PT) begin
         out_idx_ff  <= pt_idx_ff;
         out_att_ff  <= att_ff;
         out_last_ff <= cmd.is_last;
      end else if (cmd.op == OP_EMIT_FL) begin
         out_idx_ff  <= fl_idx_ff;
         out_att_ff  <= att_ff;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_point_index = out_idx_ff;
   assign rsp_attenuation = out_att_ff;
   assign rsp_is_last     = out_last_ff;

   assign st.pt_pend  = pt_pend_ff;
   assign st.fl_pend  = fl_pend_ff;
   assign st.out_busy = out_valid_ff;

   assign upd_keep = (cmd.op == OP_UPDATE) && !last_ff;

   `ASSERT_ALWAYS(a_pw_bound, clock, reset, pw_ff <= PW_W'(MAX_POINTS), "counter past limit")
   `ASSERT_NEXT(a_peak_floor, clock, reset, upd_keep, peak_ff >= PEAK_FLOOR, "peak below floor")

endmodule

// File: sv/peak_envelope_level_meter_unit.sv
// Peak envelope level meter. One sample frame is taken per beat on req_if; after the
// accepting cycle five steps run (gain, decay, attack compare, attack product,
// envelope update), three of them on one shared 32x32 multiplier, and a check step
// follows, with req ready low until the sequencer is idle again. A frame that reports
// a point runs a bitwise threshold search in place of the check step, then emits each
// result; the output register holds one beat, so a flush behind a regular point waits
// for that beat to leave. A stalled result holds the sequencer. Configuration writes
// on csr_* take effect at once and belong between frames.
module peak_envelope_level_meter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data,
   pelm_req_if.sink    req_if,
   pelm_rsp_if.source  rsp_if
);
   import pelm_pkg::*;

   cmd_type    cmd;
   status_type st;

   pelm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .st        (st),
      .cmd       (cmd)
   );

   pelm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_left_sample  (req_if.left_sample),
      .req_right_sample (req_if.right_sample),
      .req_last_sample  (req_if.last_sample),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_point_index  (rsp_if.point_index),
      .rsp_attenuation  (rsp_if.attenuation),
      .rsp_is_last      (rsp_if.is_last),
      .cmd              (cmd),
      .st               (st)
   );

endmodule
